@@ hw/rtl/spot_pkg.sv @@
// Shared widths, shape and pair codes, and pipeline types for the shape pair overlap test.
package spot_pkg;

  localparam int FUNC_W     = 4;
  localparam int XY_W       = 32;
  localparam int SIZE_W     = 31;
  localparam int ANCHOR_W   = 2;
  localparam int TEXT_LEN_W = 9;

  localparam int COORD_W = 34;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int MAG_W   = 34;
  localparam int HALF_W  = MAG_W / 2;
  localparam int PP_W    = 2 * HALF_W;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int RAD_W   = SIZE_W + 2;

  localparam int ADV_SH_HI = 11;
  localparam int ADV_SH_LO = 9;

  localparam logic [1:0] SHAPE_CIRCLE = 2'd0;
  localparam logic [1:0] SHAPE_RECT   = 2'd1;
  localparam logic [1:0] SHAPE_LINE   = 2'd2;
  localparam logic [1:0] SHAPE_TEXT   = 2'd3;

  localparam logic [FUNC_W-1:0] FN_CC = {SHAPE_CIRCLE, SHAPE_CIRCLE};
  localparam logic [FUNC_W-1:0] FN_CR = {SHAPE_CIRCLE, SHAPE_RECT};
  localparam logic [FUNC_W-1:0] FN_RC = {SHAPE_RECT,   SHAPE_CIRCLE};
  localparam logic [FUNC_W-1:0] FN_RR = {SHAPE_RECT,   SHAPE_RECT};
  localparam logic [FUNC_W-1:0] FN_TC = {SHAPE_TEXT,   SHAPE_CIRCLE};
  localparam logic [FUNC_W-1:0] FN_TR = {SHAPE_TEXT,   SHAPE_RECT};
  localparam logic [FUNC_W-1:0] FN_CT = {SHAPE_CIRCLE, SHAPE_TEXT};
  localparam logic [FUNC_W-1:0] FN_RT = {SHAPE_RECT,   SHAPE_TEXT};
  localparam logic [FUNC_W-1:0] FN_TT = {SHAPE_TEXT,   SHAPE_TEXT};

  localparam logic [ANCHOR_W-1:0] ANCHOR_START = 2'd0;
  localparam logic [ANCHOR_W-1:0] ANCHOR_END   = 2'd2;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_BOX  = 2'd1,
    MODE_DISC = 2'd2
  } mode_e;

  typedef struct packed {
    mode_e                      mode;
    logic                       incl;
    logic signed [COORD_W-1:0]  ax_lo;
    logic signed [COORD_W-1:0]  ax_hi;
    logic signed [COORD_W-1:0]  ay_lo;
    logic signed [COORD_W-1:0]  ay_hi;
    logic signed [COORD_W-1:0]  bx_lo;
    logic signed [COORD_W-1:0]  bx_hi;
    logic signed [COORD_W-1:0]  by_lo;
    logic signed [COORD_W-1:0]  by_hi;
    logic        [RAD_W-1:0]    rad;
  } bounds_t;

  typedef struct packed {
    logic  valid;
    mode_e mode;
    logic  incl;
    logic  box_hit;
  } ctrl_t;

  typedef struct packed {
    logic [MAG_W-1:0] mag_x;
    logic [MAG_W-1:0] mag_y;
    logic [RAD_W-1:0] rad;
  } dist_t;

endpackage

@@ hw/rtl/shape_pair_overlap_test.sv @@
// Top level of the shape pair overlap test: input register, operand setup, clamp and compare.
// Each accepted beat shows its flag on overlap_o, marked by valid_o, once it has passed every stage below.
// Throughput: one beat per cycle; busy stays low, so start is taken in every cycle.
// The path is six register stages: input, bounds, clamp, partial products, squares, result.
// Reset clears every valid bit; no beat is lost or invented, and the receiver cannot stall.
module shape_pair_overlap_test
  import spot_pkg::*;
#(
  parameter int MAX_TEXT_LEN = 511
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [FUNC_W-1:0]        func_i,
  input  logic signed [XY_W-1:0]   a_x_i,
  input  logic signed [XY_W-1:0]   a_y_i,
  input  logic [SIZE_W-1:0]        a_size1_i,
  input  logic [SIZE_W-1:0]        a_size2_i,
  input  logic signed [XY_W-1:0]   b_x_i,
  input  logic signed [XY_W-1:0]   b_y_i,
  input  logic [SIZE_W-1:0]        b_size1_i,
  input  logic [SIZE_W-1:0]        b_size2_i,
  input  logic [ANCHOR_W-1:0]      text_anchor_i,
  input  logic [TEXT_LEN_W-1:0]    text_len_i,
  output logic                     valid_o,
  output logic                     overlap_o
);

  localparam int LEN_W  = $clog2(MAX_TEXT_LEN + 1);
  localparam int NW     = (LEN_W > TEXT_LEN_W) ? LEN_W : TEXT_LEN_W;
  localparam int FULL_W = NW + ADV_SH_HI + 1;

  logic                    in_valid_q;
  logic [FUNC_W-1:0]       func_q;
  logic signed [XY_W-1:0]  a_x_q;
  logic signed [XY_W-1:0]  a_y_q;
  logic [SIZE_W-1:0]       a_size1_q;
  logic [SIZE_W-1:0]       a_size2_q;
  logic signed [XY_W-1:0]  b_x_q;
  logic signed [XY_W-1:0]  b_y_q;
  logic [SIZE_W-1:0]       b_size1_q;
  logic [SIZE_W-1:0]       b_size2_q;
  logic [ANCHOR_W-1:0]     text_anchor_q;
  logic [TEXT_LEN_W-1:0]   text_len_q;

  logic                    s1_valid_q;
  bounds_t                 s1_d;
  bounds_t                 s1_q;
  ctrl_t                   s2_ctrl_d;
  ctrl_t                   s2_ctrl_q;
  dist_t                   s2_dist_d;
  dist_t                   s2_dist_q;

  logic [NW-1:0]           len_ext;
  logic [NW-1:0]           len_max;
  logic [NW-1:0]           len_n;
  logic [FULL_W-1:0]       full;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      s1_valid_q <= 1'b0;
      s2_ctrl_q  <= '0;
    end else begin
      in_valid_q <= start && !busy;
      s1_valid_q <= in_valid_q;
      s2_ctrl_q  <= s2_ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      func_q        <= func_i;
      a_x_q         <= a_x_i;
      a_y_q         <= a_y_i;
      a_size1_q     <= a_size1_i;
      a_size2_q     <= a_size2_i;
      b_x_q         <= b_x_i;
      b_y_q         <= b_y_i;
      b_size1_q     <= b_size1_i;
      b_size2_q     <= b_size2_i;
      text_anchor_q <= text_anchor_i;
      text_len_q    <= text_len_i;
    end
    s1_q      <= s1_d;
    s2_dist_q <= s2_dist_d;
  end

  assign len_ext = NW'(text_len_q);
  assign len_max = NW'(MAX_TEXT_LEN);
  assign len_n   = (len_ext > len_max) ? len_max : len_ext;
  assign full    = (FULL_W'(len_n) << ADV_SH_HI) + (FULL_W'(len_n) << ADV_SH_LO);

  always_comb begin
    logic signed [COORD_W-1:0] ax, ay, bx, by;
    logic signed [COORD_W-1:0] aw, ah, bw, bh;
    logic signed [COORD_W-1:0] tx, ty, full_s, half_s, s0, s1;
    ax     = COORD_W'(a_x_q);
    ay     = COORD_W'(a_y_q);
    bx     = COORD_W'(b_x_q);
    by     = COORD_W'(b_y_q);
    aw     = COORD_W'(a_size1_q);
    ah     = COORD_W'(a_size2_q);
    bw     = COORD_W'(b_size1_q);
    bh     = COORD_W'(b_size2_q);
    tx     = (func_q[3:2] == SHAPE_TEXT) ? ax : bx;
    ty     = (func_q[3:2] == SHAPE_TEXT) ? ay : by;
    full_s = COORD_W'(full);
    half_s = full_s >>> 1;
    case (text_anchor_q)
      ANCHOR_START: begin
        s0 = tx;
        s1 = tx + full_s;
      end
      ANCHOR_END: begin
        s0 = tx - full_s;
        s1 = tx;
      end
      default: begin
        s0 = tx - half_s;
        s1 = tx + half_s;
      end
    endcase

    s1_d       = '0;
    s1_d.mode  = MODE_NONE;
    s1_d.incl  = 1'b0;
    s1_d.ax_lo = ax;
    s1_d.ax_hi = ax;
    s1_d.ay_lo = ay;
    s1_d.ay_hi = ay;
    s1_d.bx_lo = bx;
    s1_d.bx_hi = bx;
    s1_d.by_lo = by;
    s1_d.by_hi = by;
    s1_d.rad   = RAD_W'(a_size1_q);
    case (func_q)
      FN_CC: begin
        s1_d.mode = MODE_DISC;
        s1_d.rad  = RAD_W'(a_size1_q) + RAD_W'(b_size1_q);
      end
      FN_CR: begin
        s1_d.mode  = MODE_DISC;
        s1_d.bx_hi = bx + bw;
        s1_d.by_hi = by + bh;
      end
      FN_RC: begin
        s1_d.mode  = MODE_DISC;
        s1_d.rad   = RAD_W'(b_size1_q);
        s1_d.ax_lo = bx;
        s1_d.ax_hi = bx;
        s1_d.ay_lo = by;
        s1_d.ay_hi = by;
        s1_d.bx_lo = ax;
        s1_d.bx_hi = ax + aw;
        s1_d.by_lo = ay;
        s1_d.by_hi = ay + ah;
      end
      FN_RR: begin
        s1_d.mode  = MODE_BOX;
        s1_d.ax_hi = ax + aw;
        s1_d.ay_hi = ay + ah;
        s1_d.bx_hi = bx + bw;
        s1_d.by_hi = by + bh;
      end
      FN_TC: begin
        s1_d.mode  = MODE_DISC;
        s1_d.incl  = 1'b1;
        s1_d.rad   = RAD_W'(b_size1_q);
        s1_d.ax_lo = bx;
        s1_d.ax_hi = bx;
        s1_d.ay_lo = by;
        s1_d.ay_hi = by;
        s1_d.bx_lo = s0;
        s1_d.bx_hi = s1;
        s1_d.by_lo = ty;
        s1_d.by_hi = ty;
      end
      FN_CT: begin
        s1_d.mode  = MODE_DISC;
        s1_d.incl  = 1'b1;
        s1_d.bx_lo = s0;
        s1_d.bx_hi = s1;
        s1_d.by_lo = ty;
        s1_d.by_hi = ty;
      end
      FN_TR: begin
        s1_d.mode  = MODE_BOX;
        s1_d.ax_lo = s0;
        s1_d.ax_hi = s1;
        s1_d.ay_lo = ty;
        s1_d.ay_hi = ty;
        s1_d.bx_hi = bx + bw;
        s1_d.by_hi = by + bh;
      end
      FN_RT: begin
        s1_d.mode  = MODE_BOX;
        s1_d.ax_hi = ax + aw;
        s1_d.ay_hi = ay + ah;
        s1_d.bx_lo = s0;
        s1_d.bx_hi = s1;
        s1_d.by_lo = ty;
        s1_d.by_hi = ty;
      end
      default: s1_d.mode = MODE_NONE;
    endcase
  end

  always_comb begin
    logic signed [COORD_W-1:0] px, py;
    logic signed [DIFF_W-1:0]  dx, dy;
    px = (s1_q.ax_lo > s1_q.bx_hi) ? s1_q.bx_hi : s1_q.ax_lo;
    px = (px < s1_q.bx_lo) ? s1_q.bx_lo : px;
    py = (s1_q.ay_lo > s1_q.by_hi) ? s1_q.by_hi : s1_q.ay_lo;
    py = (py < s1_q.by_lo) ? s1_q.by_lo : py;
    dx = DIFF_W'(s1_q.ax_lo) - DIFF_W'(px);
    dy = DIFF_W'(s1_q.ay_lo) - DIFF_W'(py);

    s2_dist_d.mag_x = dx[DIFF_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
    s2_dist_d.mag_y = dy[DIFF_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
    s2_dist_d.rad   = s1_q.rad;

    s2_ctrl_d.valid   = s1_valid_q;
    s2_ctrl_d.mode    = s1_q.mode;
    s2_ctrl_d.incl    = s1_q.incl;
    s2_ctrl_d.box_hit = (s1_q.ax_lo <= s1_q.bx_hi) && (s1_q.bx_lo <= s1_q.ax_hi)
                     && (s1_q.ay_lo <= s1_q.by_hi) && (s1_q.by_lo <= s1_q.ay_hi);
  end

  spot_dist_cmp u_dist_cmp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (s2_ctrl_q),
    .dist_i  (s2_dist_q),
    .valid_o (valid_o),
    .hit_o   (overlap_o)
  );

endmodule

@@ hw/rtl/spot_dist_cmp.sv @@
// Squared-distance pipeline: partial products, square assembly and radius compare.
module spot_dist_cmp
  import spot_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  ctrl_t ctrl_i,
  input  dist_t dist_i,
  output logic  valid_o,
  output logic  hit_o
);

  logic [MAG_W-1:0]  op     [3];
  logic [PP_W-1:0]   pp_hh_d [3];
  logic [PP_W-1:0]   pp_hl_d [3];
  logic [PP_W-1:0]   pp_ll_d [3];
  logic [PP_W-1:0]   pp_hh_q [3];
  logic [PP_W-1:0]   pp_hl_q [3];
  logic [PP_W-1:0]   pp_ll_q [3];
  logic [SQ_W-1:0]   sq_d    [3];
  logic [SQ_W-1:0]   sq_q    [3];
  logic [SQ_W:0]     dsum;
  ctrl_t             c3_q;
  ctrl_t             c4_q;
  logic              valid_q;
  logic              hit_q;
  logic              hit_d;

  assign op[0] = dist_i.mag_x;
  assign op[1] = dist_i.mag_y;
  assign op[2] = MAG_W'(dist_i.rad);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pp_hh_d[i] = op[i][MAG_W-1:HALF_W] * op[i][MAG_W-1:HALF_W];
      pp_hl_d[i] = op[i][MAG_W-1:HALF_W] * op[i][HALF_W-1:0];
      pp_ll_d[i] = op[i][HALF_W-1:0] * op[i][HALF_W-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_d[i] = (SQ_W'(pp_hh_q[i]) << (2 * HALF_W)) + (SQ_W'(pp_hl_q[i]) << (HALF_W + 1))
              + SQ_W'(pp_ll_q[i]);
    end
  end

  assign dsum = (SQ_W + 1)'(sq_q[0]) + (SQ_W + 1)'(sq_q[1]);

  always_comb begin
    hit_d = 1'b0;
    case (c4_q.mode)
      MODE_BOX:  hit_d = c4_q.box_hit;
      MODE_DISC: hit_d = c4_q.incl ? (dsum <= (SQ_W + 1)'(sq_q[2]))
                                   : (dsum <  (SQ_W + 1)'(sq_q[2]));
      default:   hit_d = 1'b0;
    endcase
    hit_d = hit_d & c4_q.valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c3_q    <= '0;
      c4_q    <= '0;
      valid_q <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      c3_q    <= ctrl_i;
      c4_q    <= c3_q;
      valid_q <= c4_q.valid;
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pp_hh_q <= pp_hh_d;
    pp_hl_q <= pp_hl_d;
    pp_ll_q <= pp_ll_d;
    sq_q    <= sq_d;
  end

  assign valid_o = valid_q;
  assign hit_o   = hit_q;

endmodule

@@ hw/rtl/spot_checker.sv @@
// Port-level checks on the shape pair overlap test, bound to its top level.
module spot_checker
  import spot_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic [FUNC_W-1:0] func_i,
  input logic              valid_o,
  input logic              overlap_o
);

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##6 valid_o)
    else $error("result beat missing six cycles after accept");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start && !busy, 6))
    else $error("result beat without a matching accept");

  a_flag_gated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_o |-> !overlap_o)
    else $error("overlap flag outside a result beat");

  a_unsupported_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (func_i[3:2] == SHAPE_LINE || func_i[1:0] == SHAPE_LINE
                        || func_i == FN_TT)) |-> ##6 !overlap_o)
    else $error("overlap flagged for an unsupported pair");

endmodule

bind shape_pair_overlap_test spot_checker u_spot_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .start     (start),
  .busy      (busy),
  .func_i    (func_i),
  .valid_o   (valid_o),
  .overlap_o (overlap_o)
);

@@ tb/sv/tb_shape_pair_overlap_test.sv @@
// Self-checking testbench for the shape pair overlap test: directed and random shape pairs.
module tb_shape_pair_overlap_test
  import spot_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          TEXT_CAP     = 511;
  localparam longint      CHAR_STEP    = 2560;
  localparam int          RANDOM_PAIRS = 1524;
  localparam int          LIMIT        = 200000;
  localparam int          TAIL         = 12;

  localparam logic signed [XY_W-1:0] XY_MIN = 32'sh8000_0000;
  localparam logic signed [XY_W-1:0] XY_MAX = 32'sh7FFF_FFFF;
  localparam logic [SIZE_W-1:0]      SZ_MAX = '1;

  localparam logic [ANCHOR_W-1:0] ANCHOR_MID = 2'd1;
  localparam logic [ANCHOR_W-1:0] ANCHOR_ODD = 2'd3;

  localparam logic [FUNC_W-1:0] LIVE_PAIRS [8] = '{
    FN_CC, FN_CR, FN_RC, FN_RR, FN_TC, FN_TR, FN_CT, FN_RT
  };
  localparam logic [FUNC_W-1:0] ODD_PAIRS [7] = '{
    {SHAPE_CIRCLE, SHAPE_LINE}, {SHAPE_RECT, SHAPE_LINE}, {SHAPE_LINE, SHAPE_CIRCLE},
    {SHAPE_LINE, SHAPE_RECT}, {SHAPE_LINE, SHAPE_LINE}, {SHAPE_LINE, SHAPE_TEXT},
    {SHAPE_TEXT, SHAPE_LINE}
  };

  typedef struct {
    logic [FUNC_W-1:0]       func;
    logic signed [XY_W-1:0]  ax;
    logic signed [XY_W-1:0]  ay;
    logic [SIZE_W-1:0]       as1;
    logic [SIZE_W-1:0]       as2;
    logic signed [XY_W-1:0]  bx;
    logic signed [XY_W-1:0]  by;
    logic [SIZE_W-1:0]       bs1;
    logic [SIZE_W-1:0]       bs2;
    logic [ANCHOR_W-1:0]     anchor;
    logic [TEXT_LEN_W-1:0]   tlen;
    int unsigned             gap;
    bit                      drain;
  } shape_pair_t;

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    start         = 1'b0;
  logic                    busy;
  logic [FUNC_W-1:0]       func_i        = '0;
  logic signed [XY_W-1:0]  a_x_i         = '0;
  logic signed [XY_W-1:0]  a_y_i         = '0;
  logic [SIZE_W-1:0]       a_size1_i     = '0;
  logic [SIZE_W-1:0]       a_size2_i     = '0;
  logic signed [XY_W-1:0]  b_x_i         = '0;
  logic signed [XY_W-1:0]  b_y_i         = '0;
  logic [SIZE_W-1:0]       b_size1_i     = '0;
  logic [SIZE_W-1:0]       b_size2_i     = '0;
  logic [ANCHOR_W-1:0]     text_anchor_i = '0;
  logic [TEXT_LEN_W-1:0]   text_len_i    = '0;
  logic                    valid_o;
  logic                    overlap_o;

  shape_pair_t pending [$];
  bit          overlap_due [$];
  shape_pair_t next_pair;
  shape_pair_t in_flight;
  bit          have_next  = 1'b0;
  int unsigned idle_left  = 0;
  bit          quiet      = 1'b0;
  bit          drain_next = 1'b0;
  int          n_sent     = 0;
  int          n_flags    = 0;
  int          n_hits     = 0;
  int          n_drains   = 0;
  int          n_fail     = 0;
  int          cycles     = 0;

  shape_pair_overlap_test #(
    .MAX_TEXT_LEN(TEXT_CAP)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .func_i       (func_i),
    .a_x_i        (a_x_i),
    .a_y_i        (a_y_i),
    .a_size1_i    (a_size1_i),
    .a_size2_i    (a_size2_i),
    .b_x_i        (b_x_i),
    .b_y_i        (b_y_i),
    .b_size1_i    (b_size1_i),
    .b_size2_i    (b_size2_i),
    .text_anchor_i(text_anchor_i),
    .text_len_i   (text_len_i),
    .valid_o      (valid_o),
    .overlap_o    (overlap_o)
  );

  function automatic logic [127:0] sq_mag(longint v);
    logic [127:0] m;
    m = 128'((v < 0) ? -v : v);
    return m * m;
  endfunction

  function automatic bit dist_below(longint dx, longint dy, longint r, bit incl);
    logic [127:0] d;
    logic [127:0] q;
    d = sq_mag(dx) + sq_mag(dy);
    q = sq_mag(r);
    return incl ? (d <= q) : (d < q);
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v;
  endfunction

  function automatic bit disc_box(longint cx, longint cy, longint r,
                                  longint rx, longint ry, longint w, longint h);
    return dist_below(cx - clamp(cx, rx, rx + w), cy - clamp(cy, ry, ry + h), r, 1'b0);
  endfunction

  function automatic bit overlap_of(shape_pair_t p);
    longint ax, ay, aw, ah, bx, by, bw, bh;
    longint tx, ty, ox, oy, ow, oh, n, full, s0, s1;
    logic [1:0] other;
    ax = longint'(p.ax); ay = longint'(p.ay); aw = longint'(p.as1); ah = longint'(p.as2);
    bx = longint'(p.bx); by = longint'(p.by); bw = longint'(p.bs1); bh = longint'(p.bs2);
    case (p.func)
      FN_CC: return dist_below(ax - bx, ay - by, aw + bw, 1'b0);
      FN_CR: return disc_box(ax, ay, aw, bx, by, bw, bh);
      FN_RC: return disc_box(bx, by, bw, ax, ay, aw, ah);
      FN_RR: return !(ax + aw < bx || bx + bw < ax || ay + ah < by || by + bh < ay);
      FN_TC, FN_TR, FN_CT, FN_RT: begin
        if (p.func[3:2] == SHAPE_TEXT) begin
          tx = ax; ty = ay; ox = bx; oy = by; ow = bw; oh = bh; other = p.func[1:0];
        end else begin
          tx = bx; ty = by; ox = ax; oy = ay; ow = aw; oh = ah; other = p.func[3:2];
        end
        n = (p.tlen > TEXT_CAP) ? longint'(TEXT_CAP) : longint'(p.tlen);
        full = CHAR_STEP * n;
        if (p.anchor == ANCHOR_START) begin
          s0 = tx; s1 = tx + full;
        end else if (p.anchor == ANCHOR_END) begin
          s0 = tx - full; s1 = tx;
        end else begin
          s0 = tx - full / 2; s1 = tx + full / 2;
        end
        if (other == SHAPE_CIRCLE) return dist_below(clamp(ox, s0, s1) - ox, ty - oy, ow, 1'b1);
        return s0 <= ox + ow && s1 >= ox && ty <= oy + oh && ty >= oy;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic signed [XY_W-1:0] jitter(int base, int unsigned k);
    int off;
    off = int'($urandom_range(0, 1 << (k + 1))) - (1 << k);
    return base + off;
  endfunction

  function automatic logic signed [XY_W-1:0] pick_xy();
    case ($urandom_range(0, 5))
      0: return XY_MIN;
      1: return XY_MAX;
      2: return '0;
      3: return '1;
      4: return 1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return SZ_MAX;
      2: return 1;
      default: return SIZE_W'($urandom);
    endcase
  endfunction

  task automatic queue_pair(shape_pair_t p);
    p.gap = quiet ? 0 : $urandom_range(0, 9);
    p.drain = drain_next;
    drain_next = 1'b0;
    pending.push_back(p);
  endtask

  task automatic add_pair(logic [FUNC_W-1:0] func,
                          logic signed [XY_W-1:0] ax, logic signed [XY_W-1:0] ay,
                          logic [SIZE_W-1:0] as1, logic [SIZE_W-1:0] as2,
                          logic signed [XY_W-1:0] bx, logic signed [XY_W-1:0] by,
                          logic [SIZE_W-1:0] bs1, logic [SIZE_W-1:0] bs2,
                          logic [ANCHOR_W-1:0] anchor, logic [TEXT_LEN_W-1:0] tlen);
    shape_pair_t p;
    p.func = func; p.ax = ax; p.ay = ay; p.as1 = as1; p.as2 = as2;
    p.bx = bx; p.by = by; p.bs1 = bs1; p.bs2 = bs2; p.anchor = anchor; p.tlen = tlen;
    queue_pair(p);
  endtask

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Driver: hold a beat while busy, wait out the drawn gap, drain before marked pairs.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        overlap_due.push_back(overlap_of(in_flight));
        n_sent++;
      end
      if (!(start && busy)) begin
        if (!have_next && pending.size() != 0 &&
            (!pending[0].drain || (overlap_due.size() == 0 && !valid_o))) begin
          next_pair = pending.pop_front();
          idle_left = next_pair.gap;
          have_next = 1'b1;
          if (next_pair.drain) n_drains++;
        end
        if (have_next && idle_left == 0) begin
          in_flight = next_pair;
          have_next = 1'b0;
          start         <= 1'b1;
          func_i        <= in_flight.func;
          a_x_i         <= in_flight.ax;
          a_y_i         <= in_flight.ay;
          a_size1_i     <= in_flight.as1;
          a_size2_i     <= in_flight.as2;
          b_x_i         <= in_flight.bx;
          b_y_i         <= in_flight.by;
          b_size1_i     <= in_flight.bs1;
          b_size2_i     <= in_flight.bs2;
          text_anchor_i <= in_flight.anchor;
          text_len_i    <= in_flight.tlen;
        end else begin
          start <= 1'b0;
          if (have_next) idle_left--;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (overlap_due.size() == 0) begin
        $error("overlap: flag with no pair pending, actual %0b", overlap_o);
        n_fail++;
      end else begin
        if (overlap_o !== overlap_due[0]) begin
          $error("overlap mismatch: expected %0b, actual %0b", overlap_due[0], overlap_o);
          n_fail++;
        end
        void'(overlap_due.pop_front());
        n_flags++;
        if (overlap_o === 1'b1) n_hits++;
      end
    end
  end

  initial begin
    shape_pair_t p;
    int          bx0;
    int          by0;
    int unsigned k;
    int unsigned n;
    int unsigned mode;

    add_pair(FN_CC, 0, 0, 256, 0, 512, 0, 256, 0, ANCHOR_START, 0);
    add_pair(FN_CC, 0, 0, 256, 0, 511, 0, 256, 0, ANCHOR_MID, 0);
    add_pair(FN_CC, XY_MIN, XY_MIN, SZ_MAX, SZ_MAX, XY_MAX, XY_MAX, SZ_MAX, SZ_MAX,
             ANCHOR_ODD, '1);
    add_pair(FN_CC, 1000, -1000, 0, 0, 1000, -1000, 0, 0, ANCHOR_END, 7);
    add_pair(FN_CR, 128, 128, 0, 0, 0, 0, 256, 256, ANCHOR_START, 3);
    add_pair(FN_CR, 1024, 1280, 1280, 0, 0, 0, 256, 256, ANCHOR_START, 0);
    add_pair(FN_RC, 0, 0, 256, 256, 1024, 1280, 1281, 0, ANCHOR_START, 0);
    add_pair(FN_RR, 0, 0, 256, 256, 256, 256, 256, 256, ANCHOR_START, 0);
    add_pair(FN_RR, 0, 0, 256, 256, 257, 0, 256, 256, ANCHOR_START, 0);
    add_pair(FN_RR, XY_MAX, XY_MAX, SZ_MAX, SZ_MAX, XY_MIN, XY_MIN, SZ_MAX, SZ_MAX,
             ANCHOR_END, '1);
    add_pair(FN_TC, 0, 0, 0, 0, 2816, 0, 256, 0, ANCHOR_START, 1);
    add_pair(FN_TC, 0, 0, 0, 0, 2816, 0, 256, 0, ANCHOR_END, 1);
    add_pair(FN_TC, 0, 0, 0, 0, 2560, 256, 256, 0, ANCHOR_MID, 2);
    add_pair(FN_TC, XY_MAX, 0, 0, 0, 0, 0, 256, 0, ANCHOR_ODD, '1);
    add_pair(FN_TR, 0, 0, 0, 0, 0, 0, 0, 0, ANCHOR_START, 0);
    add_pair(FN_TR, -2560, 256, 0, 0, 0, 0, 256, 256, ANCHOR_START, 1);
    add_pair(FN_CT, 0, 0, 0, 0, XY_MIN, 0, SZ_MAX, SZ_MAX, ANCHOR_START, '1);
    add_pair(FN_RT, XY_MIN, XY_MIN, SZ_MAX, SZ_MAX, XY_MAX, XY_MAX, 0, 0, ANCHOR_END, '1);
    add_pair(FN_TT, 0, 0, 256, 256, 0, 0, 256, 256, ANCHOR_MID, 4);
    foreach (ODD_PAIRS[i])
      add_pair(ODD_PAIRS[i], 0, 0, 256, 256, 0, 0, 256, 256, ANCHOR_START, 1);

    drain_next = 1'b1;
    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      if (i % 60 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (i % 200 == 199) drain_next = 1'b1;
      if ($urandom_range(0, 99) < 85) p.func = LIVE_PAIRS[$urandom_range(0, 7)];
      else p.func = FUNC_W'($urandom_range(0, 15));
      p.anchor = ANCHOR_W'($urandom_range(0, 3));
      mode = $urandom_range(0, 99);
      if (mode < 70) begin
        // Keep both shapes in one neighbourhood so that roughly half of them meet.
        k = $urandom_range(3, 22);
        bx0 = int'($urandom) >>> 1;
        by0 = int'($urandom) >>> 1;
        p.ax = jitter(bx0, k); p.ay = jitter(by0, k);
        p.bx = jitter(bx0, k); p.by = jitter(by0, k);
        p.as1 = SIZE_W'($urandom_range(0, 1 << k));
        p.as2 = SIZE_W'($urandom_range(0, 1 << k));
        p.bs1 = SIZE_W'($urandom_range(0, 1 << k));
        p.bs2 = SIZE_W'($urandom_range(0, 1 << k));
        n = $urandom_range(0, ((1 << k) / CHAR_STEP) + 2);
        p.tlen = (n > TEXT_CAP || $urandom_range(0, 9) == 0) ? '1 : TEXT_LEN_W'(n);
      end else if (mode < 85) begin
        p.ax = $urandom; p.ay = $urandom;
        p.as1 = SIZE_W'($urandom); p.as2 = SIZE_W'($urandom);
        p.bx = $urandom; p.by = $urandom;
        p.bs1 = SIZE_W'($urandom); p.bs2 = SIZE_W'($urandom);
        p.tlen = TEXT_LEN_W'($urandom);
      end else begin
        p.ax = pick_xy(); p.ay = pick_xy(); p.as1 = pick_size(); p.as2 = pick_size();
        p.bx = pick_xy(); p.by = pick_xy(); p.bs1 = pick_size(); p.bs2 = pick_size();
        p.tlen = ($urandom_range(0, 1) == 0) ? '1 : '0;
      end
      queue_pair(p);
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending.size() != 0 || have_next || start) @(negedge clk_i);
    while (overlap_due.size() != 0) @(negedge clk_i);
    repeat (TAIL) @(negedge clk_i);

    $display("Sent %0d shape pairs, %0d flags checked, %0d of them overlaps.",
             n_sent, n_flags, n_hits);
    $display("Sender drained the pipeline %0d times; %0d mismatches.", n_drains, n_fail);
    if (n_fail == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
